// ===== hw/rtl/i2p_pkg.sv =====
// Package for the infix-to-postfix converter: character codes, cell operations,
// precedence and operand classification shared by the stack cells and the core.
// No dependencies.
package i2p_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int CHAR_W          = 8;

	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
	localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [1:0]        prec_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP
	} cell_op_t;

	function automatic prec_t prec_of(input char_t c);
		prec_t p;
		case (c)
			CH_PLUS, CH_MINUS:          p = 2'd1;
			CH_STAR, CH_SLASH, CH_PCT:  p = 2'd2;
			CH_CARET:                   p = 2'd3;
			default:                    p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic is_operand(input char_t c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
		       ((c >= 8'h30) && (c <= 8'h39));
	endfunction

endpackage

// ===== hw/rtl/i2p_cell.sv =====
// One entry of the shifting operator stack: takes the entry above on a push,
// the entry below on a pop, and holds otherwise.
// Depends on i2p_pkg.
module i2p_cell import i2p_pkg::*; (
	input  logic     clk,
	input  cell_op_t op,
	input  char_t    from_above,
	input  char_t    from_below,
	output char_t    data
);

	char_t data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_PUSH: data_q <= from_above;
			CELL_POP:  data_q <= from_below;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/infix_to_postfix_converter_core.sv =====
// Channel   Dir  tdata                        tuser        tlast
// s_axis    in   [7:0] in_char                -            last_char
// m_axis    out  [7:0] out_char, [8] overflow char_valid   end_of_expr
//
// Operand, '(' and ignored characters are handled in the idle state. ')' and
// operators pass through a pop state that emits the operators it pops. A last
// item then flushes the entries left on the stack, or sends a bare end marker
// when the stack is empty and the item emitted no character. Pops run from
// the top cell of the stack chain, one per cycle, gated by the output register.
// Input is ready only in the idle state with the output register free.
// Reset clears the entry count, the overflow flag and the control state; stack
// cells are not cleared. A stalled output holds the pop sequence in place.
// Depends on i2p_pkg and i2p_cell.
module infix_to_postfix_converter_core import i2p_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
	input  logic        s_axis_tlast,   // last_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_char, [8] overflow, zero above
	output logic        m_axis_tuser,   // char_valid
	output logic        m_axis_tlast    // end_of_expr
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] ST_IDLE      = 2'd0;
	localparam logic [1:0] ST_POP_CLOSE = 2'd1;
	localparam logic [1:0] ST_POP_OP    = 2'd2;
	localparam logic [1:0] ST_FLUSH     = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ovf_q, ovf_d;
	logic             emitted_q, emitted_d;
	char_t            c_q, c_d;
	logic             last_q, last_d;

	logic             out_v_q;
	char_t            out_char_q;
	logic             out_cv_q, out_eoe_q, out_ovf_q;

	cell_op_t         op;
	char_t            push_char;
	char_t            cells [STACK_DEPTH];

	logic             emit, e_cv, e_eoe;
	char_t            e_char;
	logic             out_free, accept, cnt_zero, cnt_full, cnt_one, cnt_two;
	char_t            top_char, second_char, in_c;

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			char_t above, below;
			if (gi == 0) begin : g_top
				assign above = push_char;
			end else begin : g_mid
				assign above = cells[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_bot
				assign below = '0;
			end else begin : g_up
				assign below = cells[gi+1];
			end
			i2p_cell u_cell (
				.clk        (clk),
				.op         (op),
				.from_above (above),
				.from_below (below),
				.data       (cells[gi])
			);
		end
	endgenerate

	assign top_char    = cells[0];
	assign second_char = cells[1];
	assign cnt_zero    = (cnt_q == '0);
	assign cnt_full    = (cnt_q == CNT_W'(STACK_DEPTH));
	assign cnt_one     = (cnt_q == CNT_W'(1));
	assign cnt_two     = (cnt_q == CNT_W'(2));
	assign out_free    = !out_v_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign accept      = s_axis_tvalid && s_axis_tready;
	assign in_c        = s_axis_tdata;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ovf_d     = ovf_q;
		emitted_d = emitted_q;
		c_d       = c_q;
		last_d    = last_q;
		op        = CELL_HOLD;
		push_char = c_q;
		emit      = 1'b0;
		e_char    = top_char;
		e_cv      = 1'b1;
		e_eoe     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					c_d       = in_c;
					last_d    = s_axis_tlast;
					emitted_d = 1'b0;
					push_char = in_c;
					if (is_operand(in_c)) begin
						emit   = 1'b1;
						e_char = in_c;
						e_eoe  = s_axis_tlast && cnt_zero;
						if (s_axis_tlast) begin
							if (cnt_zero) ovf_d = 1'b0;
							else          state_d = ST_FLUSH;
						end
					end else if (in_c == CH_LPAREN) begin
						if (cnt_full) begin
							ovf_d = 1'b1;
						end else begin
							op    = CELL_PUSH;
							cnt_d = cnt_q + CNT_W'(1);
						end
						if (s_axis_tlast) state_d = ST_FLUSH;
					end else if (in_c == CH_RPAREN) begin
						state_d = ST_POP_CLOSE;
					end else if (prec_of(in_c) != 2'd0) begin
						state_d = ST_POP_OP;
					end else if (s_axis_tlast) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_POP_CLOSE: begin
				if (cnt_zero) begin
					state_d = last_q ? ST_FLUSH : ST_IDLE;
				end else if (top_char == CH_LPAREN) begin
					op      = CELL_POP;
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = last_q ? ST_FLUSH : ST_IDLE;
				end else if (out_free) begin
					emit      = 1'b1;
					e_eoe     = last_q && (cnt_one || (cnt_two && second_char == CH_LPAREN));
					emitted_d = 1'b1;
					op        = CELL_POP;
					cnt_d     = cnt_q - CNT_W'(1);
					if (last_q && cnt_one) begin
						ovf_d   = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			ST_POP_OP: begin
				if (!cnt_zero && top_char != CH_LPAREN && prec_of(c_q) <= prec_of(top_char)) begin
					if (out_free) begin
						emit      = 1'b1;
						emitted_d = 1'b1;
						op        = CELL_POP;
						cnt_d     = cnt_q - CNT_W'(1);
					end
				end else begin
					if (cnt_full) begin
						ovf_d = 1'b1;
					end else begin
						op    = CELL_PUSH;
						cnt_d = cnt_q + CNT_W'(1);
					end
					state_d = last_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!cnt_zero) begin
					if (out_free) begin
						emit  = 1'b1;
						e_eoe = cnt_one;
						op    = CELL_POP;
						cnt_d = cnt_q - CNT_W'(1);
						if (cnt_one) begin
							ovf_d   = 1'b0;
							state_d = ST_IDLE;
						end
					end
				end else if (emitted_q) begin
					ovf_d   = 1'b0;
					state_d = ST_IDLE;
				end else if (out_free) begin
					emit    = 1'b1;
					e_char  = '0;
					e_cv    = 1'b0;
					e_eoe   = 1'b1;
					ovf_d   = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			emitted_q <= 1'b0;
			last_q    <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			ovf_q     <= ovf_d;
			emitted_q <= emitted_d;
			last_q    <= last_d;
			if (emit)               out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		c_q <= c_d;
		if (emit) begin
			out_char_q <= e_char;
			out_cv_q   <= e_cv;
			out_eoe_q  <= e_eoe;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, out_ovf_q, out_char_q};
	assign m_axis_tuser  = out_cv_q;
	assign m_axis_tlast  = out_eoe_q;

endmodule

// ===== hw/rtl/i2p_checker.sv =====
// Port-level checks for the infix-to-postfix converter core, with the bind
// that attaches them to it.
// Depends on infix_to_postfix_converter_core.
module i2p_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item changed while stalled");

	a_marker_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("end marker without end_of_expr");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
		else $error("end marker with nonzero character");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
		else $error("padding bits set");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
